/* src/pfc_pkg.sv */
// Shared types, constants and helpers for the Playfair encryptor.
package pfc_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  localparam logic [4:0] LET_I     = 5'd8;
  localparam logic [4:0] LET_J     = 5'd9;
  localparam logic [4:0] LET_Q     = 5'd16;
  localparam logic [4:0] LET_X     = 5'd23;
  localparam logic [4:0] FILL_FULL = 5'(CELLS);
  localparam logic [4:0] LET_LIMIT = 5'(LETTERS);

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_KEY_END,
    KIND_MSG,
    KIND_MSG_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] letter;
  } in_req_t;

  typedef struct packed {
    logic [4:0] first_cipher;
    logic [4:0] second_cipher;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MSG,
    ST_CELL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic place_key;
    logic fill_step;
    logic msg_step;
    logic cell_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic msg_pair;
    logic out_free;
    logic item_key_end;
  } ctrl_sts_t;

  // J shares the cell of I.
  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LET_J) ? LET_I : l;
  endfunction

endpackage

/* src/playfair_cipher_encrypt_top.sv */
// Top level of the streaming Playfair encryptor.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries requests of
// four kinds: key letter, key end, message letter and message end. Key letters
// build the 5x5 square (J folded to I, repeats dropped); key end, or the first
// message request, fills the rest in alphabet order. Message letters are paired
// into digraphs and each completed digraph leaves as one request on the output
// channel (out_valid, out_stall, out_data) with both cipher letters.
// Sequence: a key letter is placed as it is accepted. Completing the square is
// a sweep of one candidate letter per cycle, and input stays stalled until the
// sweep sees the square full. Once the square is complete, a message letter
// that only opens a digraph is accepted, then held in the message step; one
// that closes a digraph goes through accept, cell-position read, square read
// and output load, the load waiting while out_stall holds an earlier result.
// The two read stages of the square memories lie between acceptance and load.
// The output register lets the block take the next request while a result
// waits; a digraph finished while out_stall holds waits in the load state.
// Reset (rst_n low, synchronous) empties the square and any open digraph;
// a new key needs a reset.
module playfair_cipher_encrypt_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfc_pkg::out_rsp_t out_data
);
  import pfc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer: accepts requests and walks each through fill, lookup and output.
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Square storage, digraph state and the cipher pair rule.
  pfc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result that is held by the receiver must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("output register loaded while a result is held");

  // A held result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result dropped or changed");

  // An offered result always carries known cipher letters.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result offered with unknown cipher letters");

endmodule

/* src/pfc_dp.sv */
// Datapath: key square memories, digraph builder and cipher lookup.
module pfc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pfc_pkg::in_req_t   in_data,
  input  pfc_pkg::ctrl_cmd_t cmd,
  output pfc_pkg::ctrl_sts_t sts,
  input  logic               out_stall,
  output logic               out_valid,
  output pfc_pkg::out_rsp_t  out_data
);
  import pfc_pkg::*;

  logic [4:0]  sq_mem  [CELLS];
  logic [4:0]  pos_mem [LETTERS];

  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic [4:0]  sweep_r, sweep_nxt;
  logic [4:0]  pend_let_r, pend_let_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic        out_valid_r, out_valid_nxt;
  kind_t       item_kind_r;
  logic [4:0]  item_let_r;
  logic [4:0]  pa_r, pb_r;
  logic [4:0]  ea_r, eb_r;
  out_rsp_t    out_rsp_r;

  logic [31:0] used_ext;
  logic [4:0]  place_let;
  logic        place_en;
  logic        pair;
  logic [4:0]  pair_a, pair_b;
  logic [2:0]  ra, ca, rb, cb;
  logic [4:0]  addr_a, addr_b;

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
    return 3'(p - cell_at(r, 3'd0));
  endfunction

  function automatic logic [2:0] inc_wrap(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  // Placement of one letter, from the key stream or from the completion sweep.
  always_comb begin
    used_ext  = {6'b0, used_r};
    place_let = cmd.fill_step ? sweep_r : fold_j(in_data.letter);
    place_en  = (cmd.place_key || cmd.fill_step) && (place_let < LET_LIMIT) &&
                (fill_r != FILL_FULL) && !used_ext[place_let];
    used_nxt  = place_en ? (used_r | (26'd1 << place_let)) : used_r;
    fill_nxt  = place_en ? fill_r + 5'd1 : fill_r;
    if (cmd.accept)          sweep_nxt = 5'd0;
    else if (cmd.fill_step)  sweep_nxt = sweep_r + 5'd1;
    else                     sweep_nxt = sweep_r;
  end

  // Digraph forming on the latched message item.
  always_comb begin
    pair         = 1'b0;
    pair_a       = pend_let_r;
    pair_b       = LET_X;
    pend_let_nxt = pend_let_r;
    pend_vld_nxt = pend_vld_r;
    if (cmd.msg_step) begin
      if (item_kind_r == KIND_MSG) begin
        if (!pend_vld_r) begin
          pend_let_nxt = item_let_r;
          pend_vld_nxt = 1'b1;
        end else if (item_let_r == pend_let_r) begin
          pair   = 1'b1;
          pair_b = (pend_let_r == LET_X) ? LET_Q : LET_X;
        end else begin
          pair         = 1'b1;
          pair_b       = item_let_r;
          pend_vld_nxt = 1'b0;
        end
      end else begin
        pair         = pend_vld_r;
        pend_vld_nxt = 1'b0;
      end
    end
  end

  // Pair rule on the two cell positions.
  always_comb begin
    ra = row_of(pa_r);
    rb = row_of(pb_r);
    ca = col_of(pa_r, ra);
    cb = col_of(pb_r, rb);
    if (ra == rb) begin
      addr_a = cell_at(ra, inc_wrap(ca));
      addr_b = cell_at(rb, inc_wrap(cb));
    end else if (ca == cb) begin
      addr_a = cell_at(inc_wrap(ra), ca);
      addr_b = cell_at(inc_wrap(rb), cb);
    end else begin
      addr_a = cell_at(ra, cb);
      addr_b = cell_at(rb, ca);
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_comb begin
    sts.fill_full    = (fill_r == FILL_FULL);
    sts.msg_pair     = pair;
    sts.out_free     = !out_valid_r || !out_stall;
    sts.item_key_end = (item_kind_r == KIND_KEY_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 26'd1 << LET_J;
      fill_r      <= 5'd0;
      sweep_r     <= 5'd0;
      pend_let_r  <= 5'd0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      sweep_r     <= sweep_nxt;
      pend_let_r  <= pend_let_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind_r <= in_data.kind;
      item_let_r  <= fold_j(in_data.letter);
    end
    if (cmd.out_load) begin
      out_rsp_r.first_cipher  <= ea_r;
      out_rsp_r.second_cipher <= eb_r;
    end
  end

  // Key square and its inverse.
  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[fill_r]     <= place_let;
      pos_mem[place_let] <= fill_r;
    end
    if (cmd.msg_step) begin
      pa_r <= pos_mem[pair_a];
      pb_r <= pos_mem[pair_b];
    end
    if (cmd.cell_rd) begin
      ea_r <= sq_mem[addr_a];
      eb_r <= sq_mem[addr_b];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond square size");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_r) + 1)
    else $error("used letters disagree with fill count");

  a_j_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[LET_J])
    else $error("J lost its used mark");

endmodule

/* src/pfc_ctrl.sv */
// Controller: sequences key placement, square completion and digraph encryption.
module pfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfc_pkg::in_req_t   in_data,
  input  pfc_pkg::ctrl_sts_t sts,
  output pfc_pkg::ctrl_cmd_t cmd
);
  import pfc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_data.kind)
            KIND_KEY: begin
              cmd.place_key = 1'b1;
            end
            KIND_KEY_END: begin
              if (!sts.fill_full) state_nxt = ST_FILL;
            end
            KIND_MSG: begin
              if (in_data.letter < LET_LIMIT) begin
                state_nxt = sts.fill_full ? ST_MSG : ST_FILL;
              end
            end
            KIND_MSG_END: begin
              state_nxt = sts.fill_full ? ST_MSG : ST_FILL;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (sts.fill_full) begin
          state_nxt = sts.item_key_end ? ST_IDLE : ST_MSG;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_MSG: begin
        cmd.msg_step = 1'b1;
        state_nxt    = sts.msg_pair ? ST_CELL : ST_IDLE;
      end
      ST_CELL: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_msg_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSG) |-> sts.fill_full)
    else $error("message step on an incomplete square");

  a_fill_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && sts.fill_full && !sts.item_key_end) |=> (state_r == ST_MSG))
    else $error("completed square did not resume the message request");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a request is still in progress");

endmodule
